### hdl/acfb_pkg.sv
// Shared constants, types and helpers for the ATA command FIS builder.
// Used by the top level and its port checker; depends on nothing else.
package acfb_pkg;

  localparam int unsigned CapW   = 64;
  localparam int unsigned LbaW   = 64;
  localparam int unsigned CountW = 16;
  localparam int unsigned WordW  = 32;
  localparam int unsigned CfgIdxW = 2;

  typedef logic [7:0] byte_t;

  localparam byte_t FIS_TYPE_H2D = 8'h27;
  localparam byte_t FIS_CBIT     = 8'h80;
  localparam byte_t OP_IDENTIFY  = 8'hEC;
  localparam byte_t OP_READ      = 8'hC8;
  localparam byte_t OP_READ_EXT  = 8'h25;
  localparam byte_t OP_WRITE     = 8'hCA;
  localparam byte_t OP_WRITE_EXT = 8'h35;
  localparam byte_t OP_FLUSH     = 8'hE7;
  localparam byte_t OP_FLUSH_EXT = 8'hEA;
  localparam byte_t DEV_LBA      = 8'h40;

  localparam logic [28:0] LIMIT28 = 29'h1000_0000;

  localparam logic [1:0] ACT_IDENTIFY = 2'd0;
  localparam logic [1:0] ACT_READ     = 2'd1;
  localparam logic [1:0] ACT_WRITE    = 2'd2;
  localparam logic [1:0] ACT_FLUSH    = 2'd3;

  localparam logic [CfgIdxW-1:0] REG_CAPACITY  = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_LBA48     = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_FLUSH_EXT = 2'd2;

  typedef struct packed {
    logic             accepted;
    logic [WordW-1:0] word0;
    logic [WordW-1:0] word1;
    logic [WordW-1:0] word2;
    logic [WordW-1:0] word3;
    logic [WordW-1:0] word4;
  } fis_result_t;

  function automatic logic [WordW-1:0] head_word(input byte_t opcode);
    head_word = {8'h00, opcode, FIS_CBIT, FIS_TYPE_H2D};
  endfunction

endpackage

### hdl/ata_command_fis_builder.sv
// Top level of the ATA command FIS builder: input register, range check and
// FIS packing, result register. Depends on acfb_pkg.
//
// Usage: the input channel (in_valid, in_stall, in_action, in_first_block,
// in_sector_count) takes one request per item. The result channel
// (out_valid, out_stall, out_accepted, out_fis_word0..4) returns exactly one
// Register Host-to-Device FIS per request, in order. A rejected request
// returns out_accepted low and all dwords zero.
// An accepted item is held in the input register and then shows in the result
// register. Throughput is one item per cycle while out_stall is low; the range
// check is a single 64-bit subtract and compare between the two registers.
// The configuration port (cfg_we, cfg_index, cfg_data) writes the device
// capacity, the LBA48 mode bit and the FLUSH CACHE EXT bit; write it only
// while no request is in flight.
// Reset clears both valid flags and all configuration registers.
// When the receiver stalls, the result holds steady; the input register
// still fills, and in_stall rises only once both stages are occupied.
module ata_command_fis_builder (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [1:0]                        in_action,
  input  logic [acfb_pkg::LbaW-1:0]         in_first_block,
  input  logic [acfb_pkg::CountW-1:0]       in_sector_count,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              out_accepted,
  output logic [acfb_pkg::WordW-1:0]        out_fis_word0,
  output logic [acfb_pkg::WordW-1:0]        out_fis_word1,
  output logic [acfb_pkg::WordW-1:0]        out_fis_word2,
  output logic [acfb_pkg::WordW-1:0]        out_fis_word3,
  output logic [acfb_pkg::WordW-1:0]        out_fis_word4,
  input  logic                              cfg_we,
  input  logic [acfb_pkg::CfgIdxW-1:0]      cfg_index,
  input  logic [acfb_pkg::CapW-1:0]         cfg_data
);

  logic [acfb_pkg::CapW-1:0]   capacity_r;
  logic                        lba48_r;
  logic                        flush_ext_r;

  logic                        s1_valid_r;
  logic [1:0]                  action_r;
  logic [acfb_pkg::LbaW-1:0]   lba_r;
  logic [acfb_pkg::CountW-1:0] count_r;

  logic                        out_valid_r;
  acfb_pkg::fis_result_t       result_r;
  acfb_pkg::fis_result_t       result_nxt;

  logic                        s2_load;
  logic                        s1_load;

  logic [acfb_pkg::CapW:0]     diff;
  logic [28:0]                 sum28;
  logic                        range_ok;
  logic                        ok48;
  logic                        ok28;
  acfb_pkg::byte_t             dev28;

  assign s2_load  = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !s2_load;
  assign s1_load  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      capacity_r  <= '0;
      lba48_r     <= 1'b0;
      flush_ext_r <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        acfb_pkg::REG_CAPACITY:  capacity_r  <= cfg_data;
        acfb_pkg::REG_LBA48:     lba48_r     <= cfg_data[0];
        acfb_pkg::REG_FLUSH_EXT: flush_ext_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (s1_load) begin
        s1_valid_r <= 1'b1;
      end else if (s2_load) begin
        s1_valid_r <= 1'b0;
      end
      if (s2_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load) begin
      action_r <= in_action;
      lba_r    <= in_first_block;
      count_r  <= in_sector_count;
    end
    if (s2_load) begin
      result_r <= result_nxt;
    end
  end

  always_comb begin
    diff  = {1'b0, capacity_r} - {1'b0, lba_r};
    sum28 = {1'b0, lba_r[27:0]} + {13'b0, count_r};
    // No borrow and a nonzero difference means the first block lies on the device.
    range_ok = (count_r != '0) && !diff[acfb_pkg::CapW] &&
               (diff[acfb_pkg::CapW-1:0] != '0) &&
               ({48'b0, count_r} <= diff[acfb_pkg::CapW-1:0]);
    ok48  = (lba_r[63:48] == '0);
    ok28  = (lba_r[63:28] == '0) && (count_r[15:8] == '0) &&
            (sum28 <= acfb_pkg::LIMIT28);
    dev28 = acfb_pkg::DEV_LBA | {4'b0, lba_r[27:24]};

    result_nxt = '0;
    case (action_r)
      acfb_pkg::ACT_IDENTIFY: begin
        result_nxt.accepted = 1'b1;
        result_nxt.word0    = acfb_pkg::head_word(acfb_pkg::OP_IDENTIFY);
      end
      acfb_pkg::ACT_FLUSH: begin
        result_nxt.accepted = 1'b1;
        result_nxt.word0    = acfb_pkg::head_word(flush_ext_r ? acfb_pkg::OP_FLUSH_EXT
                                                              : acfb_pkg::OP_FLUSH);
      end
      acfb_pkg::ACT_READ, acfb_pkg::ACT_WRITE: begin
        if (range_ok && lba48_r && ok48) begin
          result_nxt.accepted = 1'b1;
          result_nxt.word0    = acfb_pkg::head_word(
                                  (action_r == acfb_pkg::ACT_WRITE) ? acfb_pkg::OP_WRITE_EXT
                                                                    : acfb_pkg::OP_READ_EXT);
          result_nxt.word1    = {acfb_pkg::DEV_LBA, lba_r[23:0]};
          result_nxt.word2    = {8'h00, lba_r[47:24]};
          result_nxt.word3    = {16'h0000, count_r};
        end else if (range_ok && !lba48_r && ok28) begin
          result_nxt.accepted = 1'b1;
          result_nxt.word0    = acfb_pkg::head_word(
                                  (action_r == acfb_pkg::ACT_WRITE) ? acfb_pkg::OP_WRITE
                                                                    : acfb_pkg::OP_READ);
          result_nxt.word1    = {dev28, lba_r[23:0]};
          result_nxt.word3    = {24'h000000, count_r[7:0]};
        end
      end
      default: result_nxt = '0;
    endcase
  end

  assign out_valid     = out_valid_r;
  assign out_accepted  = result_r.accepted;
  assign out_fis_word0 = result_r.word0;
  assign out_fis_word1 = result_r.word1;
  assign out_fis_word2 = result_r.word2;
  assign out_fis_word3 = result_r.word3;
  assign out_fis_word4 = result_r.word4;

endmodule

### hdl/acfb_chk.sv
// Port-level checker for the ATA command FIS builder, bound to the top level.
// Depends on acfb_pkg.
module acfb_chk (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       out_valid,
  input logic                       out_stall,
  input logic                       out_accepted,
  input logic [acfb_pkg::WordW-1:0] out_fis_word0,
  input logic [acfb_pkg::WordW-1:0] out_fis_word1,
  input logic [acfb_pkg::WordW-1:0] out_fis_word2,
  input logic [acfb_pkg::WordW-1:0] out_fis_word3,
  input logic [acfb_pkg::WordW-1:0] out_fis_word4
);

  // A rejected request carries an all-zero FIS.
  a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_accepted |->
      (out_fis_word0 == '0) && (out_fis_word1 == '0) && (out_fis_word2 == '0) &&
      (out_fis_word3 == '0) && (out_fis_word4 == '0))
    else $error("rejected item has a nonzero FIS");

  // An accepted FIS always has the H2D type, the C bit and zero trailing bytes.
  a_accept_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_accepted |->
      (out_fis_word0[7:0] == acfb_pkg::FIS_TYPE_H2D) &&
      (out_fis_word0[15:8] == acfb_pkg::FIS_CBIT) &&
      (out_fis_word0[31:24] == 8'h00) && (out_fis_word2[31:24] == 8'h00) &&
      (out_fis_word3[31:16] == 16'h0000) && (out_fis_word4 == '0))
    else $error("accepted FIS has a malformed header or trailer");

  // The device byte always has the LBA bit set in an accepted read or write.
  a_device_lba: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_accepted && (out_fis_word1 != '0 || out_fis_word3 != '0) |->
      out_fis_word1[30])
    else $error("device byte lacks the LBA bit");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=>
      out_valid && $stable(out_accepted) && $stable(out_fis_word0) &&
      $stable(out_fis_word1) && $stable(out_fis_word3))
    else $error("stalled item changed");

  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out_valid set right after reset");

endmodule

bind ata_command_fis_builder acfb_chk u_acfb_chk (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .out_accepted  (out_accepted),
  .out_fis_word0 (out_fis_word0),
  .out_fis_word1 (out_fis_word1),
  .out_fis_word2 (out_fis_word2),
  .out_fis_word3 (out_fis_word3),
  .out_fis_word4 (out_fis_word4)
);

### verif/fis_request_checker.sv
// Checker for the ATA command FIS builder: watches the request, result and
// configuration ports, predicts each Register H2D FIS and compares it in order.
// Depends on acfb_pkg.
module fis_request_checker (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  input  logic                         in_stall,
  input  logic [1:0]                   in_action,
  input  logic [acfb_pkg::LbaW-1:0]    in_first_block,
  input  logic [acfb_pkg::CountW-1:0]  in_sector_count,
  input  logic                         out_valid,
  input  logic                         out_stall,
  input  logic                         out_accepted,
  input  logic [acfb_pkg::WordW-1:0]   out_fis_word0,
  input  logic [acfb_pkg::WordW-1:0]   out_fis_word1,
  input  logic [acfb_pkg::WordW-1:0]   out_fis_word2,
  input  logic [acfb_pkg::WordW-1:0]   out_fis_word3,
  input  logic [acfb_pkg::WordW-1:0]   out_fis_word4,
  input  logic                         cfg_we,
  input  logic [acfb_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [acfb_pkg::CapW-1:0]    cfg_data,
  output int                           mismatch_count,
  output int                           fis_outstanding
);

  localparam logic [63:0] LBA48_MAX = 64'h0000_FFFF_FFFF_FFFF;

  logic [63:0]           capacity_copy;
  logic                  lba48_copy;
  logic                  flush_ext_copy;
  acfb_pkg::fis_result_t fis_pending_q[$];
  int                    error_total;

  initial begin
    mismatch_count  = 0;
    fis_outstanding = 0;
    error_total     = 0;
    capacity_copy   = '0;
    lba48_copy      = 1'b0;
    flush_ext_copy  = 1'b0;
  end

  function automatic logic [31:0] cmd_dword(input acfb_pkg::byte_t opcode);
    return {8'h00, opcode, acfb_pkg::FIS_CBIT, acfb_pkg::FIS_TYPE_H2D};
  endfunction

  function automatic acfb_pkg::fis_result_t build_expected_fis(input logic [1:0] act,
                                                               input logic [63:0] lba,
                                                               input logic [15:0] cnt);
    acfb_pkg::fis_result_t r;
    logic                  in_range;
    logic [63:0]           room;
    logic [63:0]           room28;
    r = '0;
    room = capacity_copy - lba;
    room28 = {35'b0, acfb_pkg::LIMIT28} - lba;
    in_range = (cnt != 16'd0) && (capacity_copy != 64'd0) && (lba < capacity_copy) &&
               ({48'b0, cnt} <= room);
    case (act)
      acfb_pkg::ACT_IDENTIFY: begin
        r.accepted = 1'b1;
        r.word0 = cmd_dword(acfb_pkg::OP_IDENTIFY);
      end
      acfb_pkg::ACT_FLUSH: begin
        r.accepted = 1'b1;
        r.word0 = cmd_dword(flush_ext_copy ? acfb_pkg::OP_FLUSH_EXT : acfb_pkg::OP_FLUSH);
      end
      default: begin
        if (in_range && lba48_copy) begin
          if (lba <= LBA48_MAX) begin
            r.accepted = 1'b1;
            r.word0 = cmd_dword((act == acfb_pkg::ACT_WRITE) ? acfb_pkg::OP_WRITE_EXT
                                                             : acfb_pkg::OP_READ_EXT);
            r.word1 = {acfb_pkg::DEV_LBA, lba[23:0]};
            r.word2 = {8'h00, lba[47:24]};
            r.word3 = {16'h0000, cnt};
          end
        end else if (in_range) begin
          if (lba < {35'b0, acfb_pkg::LIMIT28} && cnt <= 16'd255 &&
              {48'b0, cnt} <= room28) begin
            r.accepted = 1'b1;
            r.word0 = cmd_dword((act == acfb_pkg::ACT_WRITE) ? acfb_pkg::OP_WRITE
                                                             : acfb_pkg::OP_READ);
            r.word1 = {acfb_pkg::DEV_LBA | {4'h0, lba[27:24]}, lba[23:0]};
            r.word3 = {16'h0000, cnt};
          end
        end
      end
    endcase
    return r;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      error_total++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    acfb_pkg::fis_result_t want_fis;
    if (!rst_n) begin
      capacity_copy  = '0;
      lba48_copy     = 1'b0;
      flush_ext_copy = 1'b0;
      fis_pending_q.delete();
    end else begin
      if (in_valid && !in_stall) begin
        fis_pending_q.push_back(build_expected_fis(in_action, in_first_block,
                                                   in_sector_count));
      end
      if (out_valid && !out_stall) begin
        if (fis_pending_q.size() == 0) begin
          error_total++;
          $display("%0t: result item with no request pending, expected none, actual %b %h",
                   $time, out_accepted, out_fis_word0);
        end else begin
          want_fis = fis_pending_q.pop_front();
          check_field("accepted", {31'b0, want_fis.accepted}, {31'b0, out_accepted});
          check_field("fis_word0", want_fis.word0, out_fis_word0);
          check_field("fis_word1", want_fis.word1, out_fis_word1);
          check_field("fis_word2", want_fis.word2, out_fis_word2);
          check_field("fis_word3", want_fis.word3, out_fis_word3);
          check_field("fis_word4", want_fis.word4, out_fis_word4);
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          acfb_pkg::REG_CAPACITY:  capacity_copy  = cfg_data;
          acfb_pkg::REG_LBA48:     lba48_copy     = cfg_data[0];
          acfb_pkg::REG_FLUSH_EXT: flush_ext_copy = cfg_data[0];
          default: ;
        endcase
      end
    end
    fis_outstanding <= fis_pending_q.size();
    mismatch_count  <= error_total;
  end

endmodule

### verif/tb_ata_command_fis_builder.sv
// Testbench top for the ATA command FIS builder: clock, reset, request and
// configuration stimulus, receiver stalls and the verdict.
// Depends on acfb_pkg, ata_command_fis_builder and fis_request_checker.
module tb_ata_command_fis_builder;

  localparam int          CYCLE_LIMIT = 200000;
  localparam int          LONG_HOLD   = 300;
  localparam logic [63:0] SPAN28      = 64'h0000_0000_1000_0000;
  localparam logic [63:0] SPAN48      = 64'h0001_0000_0000_0000;
  localparam logic [63:0] ALL_ONES    = 64'hFFFF_FFFF_FFFF_FFFF;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_action = acfb_pkg::ACT_IDENTIFY;
  logic [63:0] in_first_block = '0;
  logic [15:0] in_sector_count = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        out_accepted;
  logic [31:0] out_fis_word0;
  logic [31:0] out_fis_word1;
  logic [31:0] out_fis_word2;
  logic [31:0] out_fis_word3;
  logic [31:0] out_fis_word4;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = acfb_pkg::REG_CAPACITY;
  logic [63:0] cfg_data = '0;

  int          mismatch_count;
  int          fis_outstanding;
  int          cycle_count = 0;
  int          hold_req_seq = 0;
  logic [63:0] cur_capacity = '0;
  logic        cur_lba48 = 1'b0;

  always #2 clk = ~clk;

  ata_command_fis_builder DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_action(in_action),
    .in_first_block(in_first_block), .in_sector_count(in_sector_count),
    .out_valid(out_valid), .out_stall(out_stall), .out_accepted(out_accepted),
    .out_fis_word0(out_fis_word0), .out_fis_word1(out_fis_word1),
    .out_fis_word2(out_fis_word2), .out_fis_word3(out_fis_word3),
    .out_fis_word4(out_fis_word4),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  fis_request_checker u_checker (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_action(in_action),
    .in_first_block(in_first_block), .in_sector_count(in_sector_count),
    .out_valid(out_valid), .out_stall(out_stall), .out_accepted(out_accepted),
    .out_fis_word0(out_fis_word0), .out_fis_word1(out_fis_word1),
    .out_fis_word2(out_fis_word2), .out_fis_word3(out_fis_word3),
    .out_fis_word4(out_fis_word4),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .mismatch_count(mismatch_count), .fis_outstanding(fis_outstanding)
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_ata_command_fis_builder failed");
      $finish;
    end
  end

  initial begin
    int seen_hold;
    int seg_kind;
    int seg_len;
    int i;
    seen_hold = 0;
    @(posedge clk);
    forever begin
      if (hold_req_seq != seen_hold) begin
        seen_hold = hold_req_seq;
        repeat (LONG_HOLD) begin
          out_stall <= 1'b1;
          @(posedge clk);
        end
      end else begin
        seg_kind = $urandom_range(0, 3);
        seg_len = $urandom_range(8, 64);
        for (i = 0; i < seg_len; i++) begin
          case (seg_kind)
            0: out_stall <= 1'b0;
            1: out_stall <= ($urandom_range(0, 3) == 0);
            2: out_stall <= ($urandom_range(0, 1) == 0);
            default: out_stall <= ($urandom_range(0, 3) != 0);
          endcase
          @(posedge clk);
        end
      end
    end
  end

  task automatic send_req(input logic [1:0] act, input logic [63:0] lba,
                          input logic [15:0] cnt);
    in_valid <= 1'b1;
    in_action <= act;
    in_first_block <= lba;
    in_sector_count <= cnt;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic wait_for_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (fis_outstanding != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic apply_config(input logic [63:0] capacity, input logic lba48,
                              input logic flush_ext);
    cur_capacity = capacity;
    cur_lba48 = lba48;
    cfg_we <= 1'b1;
    cfg_index <= acfb_pkg::REG_CAPACITY;
    cfg_data <= capacity;
    @(posedge clk);
    cfg_index <= acfb_pkg::REG_LBA48;
    cfg_data <= {63'b0, lba48};
    @(posedge clk);
    cfg_index <= acfb_pkg::REG_FLUSH_EXT;
    cfg_data <= {63'b0, flush_ext};
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [63:0] pick_capacity();
    case ($urandom_range(0, 6))
      0: return 64'd0;
      1: return 64'd1;
      2: return 64'($urandom_range(1, 5000));
      3: return SPAN28 - 64'd256 + 64'($urandom_range(0, 512));
      4: return SPAN48 - 64'd256 + 64'($urandom_range(0, 512));
      5: return ALL_ONES;
      default: return rand64();
    endcase
  endfunction

  function automatic logic [63:0] pick_lba(input logic [63:0] capacity,
                                           input logic lba48);
    logic [63:0] span;
    case ($urandom_range(0, 9))
      0, 1: return rand64();
      2: return capacity - 64'd1 - 64'($urandom_range(0, 3));
      3: return capacity;
      4: return SPAN28 - 64'd1 - 64'($urandom_range(0, 300));
      5: return SPAN48 - 64'd2 + 64'($urandom_range(0, 3));
      default: begin
        if (lba48) span = (capacity > SPAN48) ? SPAN48 : capacity;
        else span = (capacity > SPAN28) ? SPAN28 : capacity;
        if (span == 64'd0) return rand64();
        return rand64() % span;
      end
    endcase
  endfunction

  function automatic logic [15:0] pick_count(input logic [63:0] capacity,
                                             input logic [63:0] lba);
    logic [63:0] room;
    room = capacity - lba;
    case ($urandom_range(0, 9))
      0: return 16'd0;
      1: return 16'($urandom);
      2: return 16'($urandom_range(250, 260));
      3: return 16'hFFFF;
      4: begin
        if (capacity > lba && room <= 64'hFFFF) return room[15:0] + 16'($urandom_range(0, 1));
        return 16'($urandom_range(1, 255));
      end
      default: return 16'($urandom_range(1, 32));
    endcase
  endfunction

  task automatic run_random_phase(input int n_items, input bit with_hold);
    int          burst_left;
    int          k;
    logic [1:0]  act;
    logic [63:0] lba;
    logic [15:0] cnt;
    if (with_hold) hold_req_seq <= hold_req_seq + 1;
    burst_left = $urandom_range(1, 24);
    for (k = 0; k < n_items; k++) begin
      case ($urandom_range(0, 9))
        0: act = acfb_pkg::ACT_IDENTIFY;
        1: act = acfb_pkg::ACT_FLUSH;
        default: act = $urandom_range(0, 1) ? acfb_pkg::ACT_WRITE : acfb_pkg::ACT_READ;
      endcase
      lba = pick_lba(cur_capacity, cur_lba48);
      cnt = pick_count(cur_capacity, lba);
      send_req(act, lba, cnt);
      burst_left--;
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 24);
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
    end
  endtask

  initial begin
    int p;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_req(acfb_pkg::ACT_IDENTIFY, ALL_ONES, 16'hFFFF);
    send_req(acfb_pkg::ACT_FLUSH, 64'h1234_5678_9ABC_DEF0, 16'h00FF);
    send_req(acfb_pkg::ACT_READ, 64'd0, 16'd1);

    wait_for_idle();
    apply_config(64'd1000, 1'b0, 1'b0);
    send_req(acfb_pkg::ACT_READ, 64'd0, 16'd1);
    send_req(acfb_pkg::ACT_WRITE, 64'd999, 16'd1);
    send_req(acfb_pkg::ACT_READ, 64'd999, 16'd2);
    send_req(acfb_pkg::ACT_WRITE, 64'd5, 16'd0);
    send_req(acfb_pkg::ACT_READ, 64'd1000, 16'd1);
    send_req(acfb_pkg::ACT_WRITE, 64'd0, 16'd255);
    send_req(acfb_pkg::ACT_READ, 64'd0, 16'd256);

    wait_for_idle();
    apply_config(ALL_ONES, 1'b0, 1'b1);
    send_req(acfb_pkg::ACT_READ, 64'h0FFF_FFFF, 16'd1);
    send_req(acfb_pkg::ACT_WRITE, 64'h0FFF_FFFF, 16'd2);
    send_req(acfb_pkg::ACT_READ, 64'h1000_0000, 16'd1);
    send_req(acfb_pkg::ACT_WRITE, 64'h0FFF_FF01, 16'd255);
    send_req(acfb_pkg::ACT_READ, 64'h0FFF_FF02, 16'd255);
    send_req(acfb_pkg::ACT_FLUSH, 64'd0, 16'd0);

    wait_for_idle();
    apply_config(ALL_ONES, 1'b1, 1'b1);
    send_req(acfb_pkg::ACT_READ, 64'h0000_FFFF_FFFF_FFFF, 16'd1);
    send_req(acfb_pkg::ACT_WRITE, SPAN48, 16'd1);
    send_req(acfb_pkg::ACT_READ, 64'hFFFF_FFFF_FFFF_FFFE, 16'd1);
    send_req(acfb_pkg::ACT_WRITE, 64'h0000_A5A5_5A5A_F00F, 16'hFFFF);
    send_req(acfb_pkg::ACT_FLUSH, ALL_ONES, 16'hFFFF);

    wait_for_idle();
    apply_config(64'h0000_0001_0000_0010, 1'b1, 1'b0);
    send_req(acfb_pkg::ACT_READ, 64'h0000_0001_0000_0000, 16'd16);
    send_req(acfb_pkg::ACT_READ, 64'h0000_0001_0000_0000, 16'd17);
    send_req(acfb_pkg::ACT_FLUSH, 64'd0, 16'd0);
    send_req(acfb_pkg::ACT_IDENTIFY, 64'd0, 16'd0);

    for (p = 0; p < 8; p++) begin
      wait_for_idle();
      apply_config(pick_capacity(), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      run_random_phase(100, (p == 1) || (p == 5));
    end

    wait_for_idle();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0 && fis_outstanding == 0) begin
      $display("tb_ata_command_fis_builder passed");
    end else begin
      $display("tb_ata_command_fis_builder failed");
    end
    $finish;
  end

endmodule
